// File: sv/assert_macros.svh
// assertion helpers, empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: sv/strlit_pkg.sv
`timescale 1ns / 1ps

package strlit_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_CLOSED = 2'd1;
  localparam logic [1:0] KIND_UNTERM = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] BEL      = 8'h07;
  localparam logic [7:0] BS       = 8'h08;
  localparam logic [7:0] FF       = 8'h0c;
  localparam logic [7:0] CR       = 8'h0d;
  localparam logic [7:0] HT       = 8'h09;
  localparam logic [7:0] VT       = 8'h0b;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_ESCAPE = 4'b0010,
    MODE_OCT1   = 4'b0100,
    MODE_OCT2   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } dec_out_t;

endpackage

// File: sv/strlit_core.sv
`timescale 1ns / 1ps

module strlit_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           in_byte,
  input  logic                 end_of_input,
  output strlit_pkg::dec_out_t dec
);
  import strlit_pkg::*;

  mode_t      mode, mode_next;
  logic [7:0] octal_value, octal_value_next;
  logic       digit;
  logic [7:0] oct_acc;

  // normal text handling, returns the result for a byte outside an escape
  function automatic res_t normal_res(input logic [7:0] b, input logic eoi);
    res_t r;
    r.last = 1'b1;
    r.data = 8'h00;
    if (eoi || b == CH_LF) begin
      r.kind = KIND_UNTERM;
    end else if (b == CH_QUOTE) begin
      r.kind = KIND_CLOSED;
    end else begin
      r.kind = KIND_DATA;
      r.data = b;
    end
    return r;
  endfunction

  assign digit   = (in_byte[7:3] == CH_ZERO[7:3]);
  assign oct_acc = {octal_value[4:0], in_byte[2:0]};

  always_comb begin
    mode_next        = mode;
    octal_value_next = octal_value;
    dec              = '0;
    unique case (mode)
      MODE_NORMAL: begin
        if (!end_of_input && in_byte == CH_BSL) begin
          mode_next = MODE_ESCAPE;
        end else begin
          dec.cnt = 2'd1;
          dec.r0  = normal_res(in_byte, end_of_input);
          if (dec.r0.kind != KIND_DATA) begin
            octal_value_next = 8'h00;
          end
        end
      end
      MODE_ESCAPE: begin
        if (end_of_input) begin
          dec.cnt          = 2'd2;
          dec.r0           = '{kind: KIND_DATA, data: CH_BSL, last: 1'b0};
          dec.r1           = '{kind: KIND_UNTERM, data: 8'h00, last: 1'b1};
          mode_next        = MODE_NORMAL;
          octal_value_next = 8'h00;
        end else if (digit) begin
          octal_value_next = {5'd0, in_byte[2:0]};
          mode_next        = MODE_OCT1;
        end else begin
          mode_next = MODE_NORMAL;
          dec.cnt   = 2'd1;
          dec.r0    = '{kind: KIND_DATA, data: in_byte, last: 1'b1};
          unique case (in_byte)
            CH_BSL, CH_QUOTE, CH_SLASH: dec.r0.data = in_byte;
            CH_A:    dec.r0.data = BEL;
            CH_B:    dec.r0.data = BS;
            CH_F:    dec.r0.data = FF;
            CH_N:    dec.r0.data = CH_LF;
            CH_R:    dec.r0.data = CR;
            CH_T:    dec.r0.data = HT;
            CH_V:    dec.r0.data = VT;
            default: begin
              dec.cnt = 2'd2;
              dec.r0  = '{kind: KIND_DATA, data: CH_BSL, last: 1'b0};
              dec.r1  = '{kind: KIND_DATA, data: in_byte, last: 1'b1};
            end
          endcase
        end
      end
      MODE_OCT1, MODE_OCT2: begin
        if (!end_of_input && digit) begin
          if (mode == MODE_OCT2) begin
            dec.cnt          = 2'd1;
            dec.r0           = '{kind: KIND_DATA, data: oct_acc, last: 1'b1};
            mode_next        = MODE_NORMAL;
            octal_value_next = 8'h00;
          end else begin
            octal_value_next = oct_acc;
            mode_next        = MODE_OCT2;
          end
        end else begin
          octal_value_next = 8'h00;
          dec.r0           = '{kind: KIND_DATA, data: octal_value, last: 1'b1};
          if (!end_of_input && in_byte == CH_BSL) begin
            dec.cnt   = 2'd1;
            mode_next = MODE_ESCAPE;
          end else begin
            dec.cnt     = 2'd2;
            dec.r0.last = 1'b0;
            dec.r1      = normal_res(in_byte, end_of_input);
            mode_next   = MODE_NORMAL;
          end
        end
      end
      default: begin
        mode_next        = MODE_NORMAL;
        octal_value_next = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NORMAL;
      octal_value <= 8'h00;
    end else if (take) begin
      mode        <= mode_next;
      octal_value <= octal_value_next;
    end
  end

endmodule

// File: sv/strlit_obuf.sv
`timescale 1ns / 1ps

module strlit_obuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  strlit_pkg::dec_out_t dec,
  output logic                 room,
  output logic                 valid,
  input  logic                 pop_ready,
  output strlit_pkg::res_t     head
);
  import strlit_pkg::*;

  res_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count, count_next;
  logic [1:0]        nput;
  logic              pop;

  // two free slots needed for the worst transaction
  assign room  = (count <= QCNT_W'(QDEPTH - 2));
  assign valid = (count != '0);
  assign pop   = valid && pop_ready;
  assign nput  = push ? dec.cnt : 2'd0;
  assign head  = q[rd_ptr];

  assign count_next = count + QCNT_W'(nput) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (nput != 2'd0) begin
      q[wr_ptr] <= dec.r0;
    end
    if (nput == 2'd2) begin
      q[wr_ptr + QPTR_W'(1)] <= dec.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(nput);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count_next;
    end
  end

endmodule

// File: sv/string_literal_escape_decoder_top.sv
`timescale 1ns / 1ps
// channel   direction  tdata             tuser             tlast
// s_axis    in         in_byte [7:0]     end_of_input [0]  -
// m_axis    out        out_byte [7:0]    out_kind [1:0]    last
//
// one input transaction per cycle while the output queue has room; the mode register updates in the same cycle
// an input yields zero, one or two results, each leaving as its own transaction
// results wait in a four-entry output queue; input stalls when fewer than two entries are free
// synchronous active-high reset returns to normal text mode with the queue empty

module string_literal_escape_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte
  input  logic       s_axis_tuser,   // end_of_input
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte
  output logic [1:0] m_axis_tuser,   // out_kind
  output logic       m_axis_tlast
);
  import strlit_pkg::*;
  `include "assert_macros.svh"

  dec_out_t dec;
  res_t     head;
  logic     take;

  assign take = s_axis_tvalid && s_axis_tready;

  strlit_core u_core (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .in_byte      (s_axis_tdata),
    .end_of_input (s_axis_tuser),
    .dec          (dec)
  );

  strlit_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .dec       (dec),
    .room      (s_axis_tready),
    .valid     (m_axis_tvalid),
    .pop_ready (m_axis_tready),
    .head      (head)
  );

  assign m_axis_tdata = head.data;
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  `ASSERT_IMPLIES(a_full_has_data, clk, rst, !s_axis_tready, m_axis_tvalid)
  `ASSERT_NEXT(a_empty_after_reset, clk, 1'b0, rst, !m_axis_tvalid)
  `ASSERT_IMPLIES(a_kind_legal, clk, rst, m_axis_tvalid, m_axis_tuser != 2'd3)
  `ASSERT_IMPLIES(a_report_shape, clk, rst,
    m_axis_tvalid && m_axis_tuser != KIND_DATA, m_axis_tdata == 8'h00 && m_axis_tlast)

endmodule

// File: bench/tb_string_literal_escape_decoder_top.sv
`timescale 1ns / 1ps

module tb_string_literal_escape_decoder_top;
  import strlit_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // in_byte
  logic       s_axis_tuser = 1'b0;    // end_of_input
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // out_byte
  logic [1:0] m_axis_tuser;           // out_kind
  logic       m_axis_tlast;

  typedef struct {
    logic [7:0] b;
    logic       eoi;
    int         n;
    res_t       r0;
    res_t       r1;
  } byte_row_t;

  mode_t      dec_mode = MODE_NORMAL;
  logic [7:0] dec_octal = 8'h00;
  res_t       step_q[$];
  res_t       decoded_q[$];
  byte_row_t  dir_tab[$];
  int         bytes_sent = 0;
  int         mismatches = 0;
  bit         calm = 1'b0;
  bit         drained = 1'b0;

  string_literal_escape_decoder_top dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #10 clk = ~clk;

  function automatic void put(logic [1:0] kind, logic [7:0] data);
    res_t r;
    r.kind = kind;
    r.data = data;
    r.last = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void end_literal();
    dec_mode = MODE_NORMAL;
    dec_octal = 8'h00;
  endfunction

  function automatic void take_plain(logic [7:0] b, logic eoi);
    if (eoi || b == CH_LF) begin
      put(KIND_UNTERM, 8'h00);
      end_literal();
    end else if (b == CH_QUOTE) begin
      put(KIND_CLOSED, 8'h00);
      end_literal();
    end else if (b == CH_BSL) begin
      dec_mode = MODE_ESCAPE;
    end else begin
      put(KIND_DATA, b);
    end
  endfunction

  function automatic void decode_step(logic [7:0] b, logic eoi);
    logic [7:0] digit;
    digit = b - CH_ZERO;
    case (dec_mode)
      MODE_NORMAL: take_plain(b, eoi);
      MODE_ESCAPE: begin
        if (eoi) begin
          put(KIND_DATA, CH_BSL);
          put(KIND_UNTERM, 8'h00);
          end_literal();
        end else if (digit < 8) begin
          dec_octal = digit;
          dec_mode = MODE_OCT1;
        end else begin
          dec_mode = MODE_NORMAL;
          case (b)
            CH_BSL:   put(KIND_DATA, CH_BSL);
            CH_QUOTE: put(KIND_DATA, CH_QUOTE);
            CH_SLASH: put(KIND_DATA, CH_SLASH);
            CH_A:     put(KIND_DATA, BEL);
            CH_B:     put(KIND_DATA, BS);
            CH_F:     put(KIND_DATA, FF);
            CH_N:     put(KIND_DATA, CH_LF);
            CH_R:     put(KIND_DATA, CR);
            CH_T:     put(KIND_DATA, HT);
            CH_V:     put(KIND_DATA, VT);
            default: begin
              put(KIND_DATA, CH_BSL);
              put(KIND_DATA, b);
            end
          endcase
        end
      end
      default: begin
        if (!eoi && digit < 8) begin
          dec_octal = {dec_octal[4:0], 3'b000} | digit;
          if (dec_mode == MODE_OCT2) begin
            put(KIND_DATA, dec_octal);
            end_literal();
          end else begin
            dec_mode = MODE_OCT2;
          end
        end else begin
          put(KIND_DATA, dec_octal);
          dec_mode = MODE_NORMAL;
          dec_octal = 8'h00;
          take_plain(b, eoi);
        end
      end
    endcase
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(99) < 75) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic add_row(logic [7:0] b, logic eoi, int n, res_t r0, res_t r1);
    byte_row_t row;
    row.b = b;
    row.eoi = eoi;
    row.n = n;
    row.r0 = r0;
    row.r1 = r1;
    dir_tab.push_back(row);
  endtask

  // starts and ends at a falling edge; valid stays high when the next byte follows at once
  task automatic send_byte(logic [7:0] b, logic eoi, int typed_n, res_t t0, res_t t1);
    int gap;
    gap = (calm || $urandom_range(99) < 65) ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= eoi;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    decode_step(b, eoi);
    if (typed_n < 0) begin
      foreach (step_q[i]) decoded_q.push_back(step_q[i]);
    end else begin
      if (typed_n > 0) decoded_q.push_back(t0);
      if (typed_n > 1) decoded_q.push_back(t1);
    end
    step_q.delete();
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_literal();
    int len;
    int r;
    int nd;
    logic [7:0] c;
    len = ($urandom_range(99) < 85) ? $urandom_range(0, 10) : $urandom_range(11, 40);
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(99);
      if (r < 50) begin
        c = 8'($urandom_range(255));
        if (c == CH_BSL || c == CH_QUOTE || c == CH_LF) c = c ^ 8'h01;
        send_byte(c, 1'b0, -1, '0, '0);
      end else if (r < 70) begin
        send_byte(CH_BSL, 1'b0, -1, '0, '0);
        case ($urandom_range(9))
          0: c = CH_BSL;
          1: c = CH_QUOTE;
          2: c = CH_SLASH;
          3: c = CH_A;
          4: c = CH_B;
          5: c = CH_F;
          6: c = CH_N;
          7: c = CH_R;
          8: c = CH_T;
          default: c = CH_V;
        endcase
        send_byte(c, 1'b0, -1, '0, '0);
      end else if (r < 85) begin
        send_byte(CH_BSL, 1'b0, -1, '0, '0);
        nd = $urandom_range(1, 3);
        repeat (nd) send_byte(CH_ZERO | 8'($urandom_range(7)), 1'b0, -1, '0, '0);
      end else if (r < 95) begin
        send_byte(CH_BSL, 1'b0, -1, '0, '0);
        send_byte(8'($urandom_range(255)), 1'b0, -1, '0, '0);
      end else begin
        send_byte(8'($urandom_range(255)), $urandom_range(9) == 0, -1, '0, '0);
      end
    end
    r = $urandom_range(99);
    if (r < 78) begin
      send_byte(CH_QUOTE, 1'b0, -1, '0, '0);
    end else if (r < 88) begin
      send_byte(CH_LF, 1'b0, -1, '0, '0);
    end else if (r < 96) begin
      send_byte(8'($urandom_range(255)), 1'b1, -1, '0, '0);
    end else begin
      send_byte(CH_BSL, 1'b0, -1, '0, '0);
      send_byte(8'($urandom_range(255)), 1'b1, -1, '0, '0);
    end
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!rst) begin
        if (calm) begin
          m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
          m_axis_tready <= 1'b0;
          stall_left--;
        end else if ($urandom_range(99) < 25) begin
          m_axis_tready <= 1'b0;
          stall_left = gap_len() - 1;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: kind %0d byte %h last %0b",
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end else begin
        want = decoded_q.pop_front();
        if (m_axis_tuser !== want.kind || m_axis_tdata !== want.data ||
            m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind %0d byte %h last %0b, got kind %0d byte %h last %0b",
                     want.kind, want.data, want.last,
                     m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    add_row(8'h00, 1'b0, 1, {KIND_DATA, 8'h00, 1'b1}, '0);
    add_row(8'hff, 1'b0, 1, {KIND_DATA, 8'hff, 1'b1}, '0);
    add_row(CH_QUOTE, 1'b0, 1, {KIND_CLOSED, 8'h00, 1'b1}, '0);
    add_row(CH_LF, 1'b0, 1, {KIND_UNTERM, 8'h00, 1'b1}, '0);
    add_row(8'hff, 1'b1, 1, {KIND_UNTERM, 8'h00, 1'b1}, '0);
    add_row(CH_BSL, 1'b0, 0, '0, '0);
    add_row(CH_N, 1'b0, -1, '0, '0);
    // unknown escape passes both bytes
    add_row(CH_BSL, 1'b0, 0, '0, '0);
    add_row(8'h71, 1'b0, 2, {KIND_DATA, CH_BSL, 1'b0}, {KIND_DATA, 8'h71, 1'b1});
    add_row(CH_BSL, 1'b0, 0, '0, '0);
    add_row(CH_LF, 1'b0, -1, '0, '0);
    // source ends right after a backslash
    add_row(CH_BSL, 1'b0, 0, '0, '0);
    add_row(8'h00, 1'b1, 2, {KIND_DATA, CH_BSL, 1'b0}, {KIND_UNTERM, 8'h00, 1'b1});
    // three digits wrap to 8 bits
    add_row(CH_BSL, 1'b0, 0, '0, '0);
    add_row(CH_ZERO + 8'd7, 1'b0, 0, '0, '0);
    add_row(CH_ZERO + 8'd7, 1'b0, 0, '0, '0);
    add_row(CH_ZERO + 8'd7, 1'b0, 1, {KIND_DATA, 8'hff, 1'b1}, '0);
    // two digits closed by a quote
    add_row(CH_BSL, 1'b0, 0, '0, '0);
    add_row(CH_ZERO + 8'd5, 1'b0, -1, '0, '0);
    add_row(CH_ZERO + 8'd6, 1'b0, -1, '0, '0);
    add_row(CH_QUOTE, 1'b0, -1, '0, '0);
    // one digit then end of source
    add_row(CH_BSL, 1'b0, 0, '0, '0);
    add_row(CH_ZERO + 8'd1, 1'b0, -1, '0, '0);
    add_row(8'h55, 1'b1, -1, '0, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i])
      send_byte(dir_tab[i].b, dir_tab[i].eoi, dir_tab[i].n, dir_tab[i].r0, dir_tab[i].r1);

    while (bytes_sent < dir_tab.size() + 1500) begin
      if ($urandom_range(99) < 8) calm = !calm;
      if (!drained && bytes_sent >= 700) begin
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        @(negedge clk);
        drained = 1'b1;
      end
      send_literal();
    end

    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    calm = 1'b1;
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
